[hdl/cfgv_pkg.sv]
// Shared types, constants and helpers for the settings image validator.
// Used by cfgv_parser, cfgv_status and config_image_validator; depends on nothing.

package cfgv_pkg;

   localparam int MAX_ITEMS       = 1024;
   localparam int MAX_IMAGE_BYTES = 16384;

   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int POS_W     = $clog2(MAX_IMAGE_BYTES) + 1;
   localparam int FR_W      = 17;
   localparam int ENTRY_W   = 16;
   localparam int BUF_W     = 15;
   localparam int IDS_W     = 11;
   localparam int CNT_W     = 16;
   localparam int FREE_W    = 14;
   localparam int TAIL_BYTES = 4;
   localparam int DRAIN_W   = $clog2(TAIL_BYTES + 1);
   localparam int MIN_IMAGE_BYTES = 12;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = BUF_W;

   localparam logic [CSR_INDEX_W-1:0] REG_BUFFER_SIZE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_ID_TABLE    = 1'b1;

   localparam logic [BUF_W-1:0] BUFFER_SIZE_RESET = 15'd16384;
   localparam logic [IDS_W-1:0] ID_TABLE_RESET    = 11'd35;

   localparam logic [31:0] START_MAGIC = 32'h5343_7630;
   localparam logic [31:0] END_MAGIC   = 32'h5343_6564;

   localparam logic RESULT_ITEM   = 1'b0;
   localparam logic RESULT_STATUS = 1'b1;
   localparam logic STATUS_VALID    = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   localparam logic [2:0] TYPE_NONE        = 3'd0;
   localparam logic [2:0] TYPE_BIG_ARRAY   = 3'd1;
   localparam logic [2:0] TYPE_SMALL_ARRAY = 3'd2;
   localparam logic [2:0] TYPE_BYTE        = 3'd3;
   localparam logic [2:0] TYPE_SHORT       = 3'd4;
   localparam logic [2:0] TYPE_LONG        = 3'd5;
   localparam logic [2:0] TYPE_LONG_LONG   = 3'd6;
   localparam logic [2:0] TYPE_BOOL        = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic        status;
      logic [13:0] item_offset;
      logic [2:0]  item_type;
      logic [5:0]  name_length;
      logic [16:0] data_length;
      logic [15:0] item_count;
      logic [13:0] free_bytes;
   } rsp_type;

   // Control from the handshake logic to the parser for one cycle.
   typedef struct packed {
      logic         item_go;
      req_type      item;
      logic         tail_go;
      logic [1:0]   tail_sel;
      logic         clear_go;
   } parse_ctl_type;

   typedef struct packed {
      logic              valid;
      logic [13:0]       offset;
      logic [2:0]        kind;
      logic [5:0]        name_len;
      logic [FR_W-1:0]   data_len;
   } rec_type;

   typedef struct packed {
      logic              error_seen;
      logic              phase_done;
      logic [POS_W-1:0]  byte_position;
      logic [POS_W-1:0]  running_offset;
      logic [CNT_W-1:0]  declared_count;
      logic [31:0]       tail_bytes;
   } summary_type;

   typedef struct packed {
      logic              ok;
      logic [FREE_W-1:0] free_bytes;
   } verdict_type;

   function automatic logic [FR_W-1:0] fixed_len(input logic [2:0] kind);
      logic [FR_W-1:0] len;
      case (kind)
         TYPE_BYTE:      len = 17'd1;
         TYPE_SHORT:     len = 17'd2;
         TYPE_LONG:      len = 17'd4;
         TYPE_LONG_LONG: len = 17'd8;
         TYPE_BOOL:      len = 17'd1;
         default:        len = 17'd0;
      endcase
      return len;
   endfunction

endpackage

[hdl/cfgv_parser.sv]
// Byte parser of the settings image: header, offset table and typed records.
// Holds the parse state and the offset table memory; depends on cfgv_pkg.

module cfgv_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  cfgv_pkg::parse_ctl_type      ctl,
   input  logic [cfgv_pkg::BUF_W-1:0]   buffer_size,
   output cfgv_pkg::rec_type            rec,
   output cfgv_pkg::summary_type        summary
);
   import cfgv_pkg::*;

   localparam logic [3:0] PH_MAGIC  = 4'd0;
   localparam logic [3:0] PH_CNT_HI = 4'd1;
   localparam logic [3:0] PH_CNT_LO = 4'd2;
   localparam logic [3:0] PH_TABLE  = 4'd3;
   localparam logic [3:0] PH_DESC   = 4'd4;
   localparam logic [3:0] PH_NAME   = 4'd5;
   localparam logic [3:0] PH_LEN_HI = 4'd6;
   localparam logic [3:0] PH_LEN_LO = 4'd7;
   localparam logic [3:0] PH_DATA   = 4'd8;
   localparam logic [3:0] PH_DONE   = 4'd9;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [3:0]         phase_ff, phase_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [POS_W-1:0]   ro_ff, ro_in;
   logic [FR_W-1:0]    fr_ff, fr_in;
   logic [7:0]         desc_ff, desc_in;
   logic [31:0]        tail_ff, tail_in;
   logic               err_ff, err_in;
   logic [ENTRY_W-1:0] last_entry_ff, last_entry_in;
   logic [ENTRY_W-1:0] rd_ff;
   logic [ENTRY_W-1:0] mem [MAX_ITEMS];

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic               pb_en;
   logic [7:0]         pb;
   logic [POS_W-1:0]   ro_inc;
   logic [FR_W-1:0]    fr_dec;
   logic [CNT_W-1:0]   cnt_new;
   logic [ENTRY_W-1:0] entry;
   logic [2:0]         pb_kind;

   assign ro_inc  = ro_ff + 1'b1;
   assign fr_dec  = fr_ff - 1'b1;
   assign cnt_new = {cnt_ff[15:8], pb};
   assign entry   = {desc_ff, pb};
   assign pb_kind = pb[7:5];

   always_comb begin
      // Once the stream is past the end, the four magic positions are read as
      // the magic itself only when the image fills the whole store.
      if (ctl.tail_go) begin
         pb_en = 1'b1;
         pb    = (pos_ff == POS_W'(buffer_size)) ? tail_ff[{~ctl.tail_sel, 3'b000} +: 8]
                                                 : 8'h00;
      end else begin
         pb_en = ctl.item_go && (pos_ff >= POS_W'(TAIL_BYTES));
         pb    = tail_ff[31:24];
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      ro_in         = ro_ff;
      fr_in         = fr_ff;
      desc_in       = desc_ff;
      tail_in       = tail_ff;
      err_in        = err_ff;
      last_entry_in = last_entry_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = entry;
      rec           = '0;

      if (pb_en && !err_ff) begin
         case (phase_ff)
            PH_MAGIC: begin
               if (ro_ff > POS_W'(3) || pb != START_MAGIC[{~ro_ff[1:0], 3'b000} +: 8]) begin
                  err_in = 1'b1;
               end else begin
                  ro_in = ro_inc;
                  if (ro_inc == POS_W'(4)) begin
                     phase_in = PH_CNT_HI;
                  end
               end
            end
            PH_CNT_HI: begin
               cnt_in   = {pb, 8'h00};
               ro_in    = ro_inc;
               phase_in = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               cnt_in = cnt_new;
               ro_in  = ro_inc;
               if (cnt_new >= CNT_W'(MAX_ITEMS)) begin
                  err_in = 1'b1;
               end else begin
                  fr_in    = FR_W'({cnt_new, 1'b0}) + FR_W'(2);
                  idx_in   = '0;
                  phase_in = PH_TABLE;
               end
            end
            PH_TABLE: begin
               if (!fr_ff[0]) begin
                  desc_in = pb;
               end else begin
                  wr_en  = 1'b1;
                  idx_in = idx_ff + 1'b1;
                  if (idx_ff == cnt_ff[IDX_W-1:0]) begin
                     last_entry_in = entry;
                  end
               end
               ro_in = ro_inc;
               fr_in = fr_dec;
               if (fr_dec == '0) begin
                  idx_in  = '0;
                  desc_in = 8'h00;
                  if (cnt_ff == '0) begin
                     // With no items the closing entry is the one written now.
                     if (ENTRY_W'(ro_inc) != entry) begin
                        err_in = 1'b1;
                     end
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_DESC;
                  end
               end
            end
            PH_DESC: begin
               if (ENTRY_W'(ro_ff) != rd_ff || pb_kind == TYPE_NONE) begin
                  err_in = 1'b1;
               end else begin
                  desc_in  = pb;
                  fr_in    = FR_W'(pb[4:0]) + 1'b1;
                  ro_in    = ro_inc;
                  phase_in = PH_NAME;
                  if (pb_kind >= TYPE_BYTE) begin
                     rec.valid    = 1'b1;
                     rec.offset   = ro_ff[13:0];
                     rec.kind     = pb_kind;
                     rec.name_len = 6'(pb[4:0]) + 1'b1;
                     rec.data_len = fixed_len(pb_kind);
                  end
               end
            end
            PH_NAME: begin
               ro_in = ro_inc;
               fr_in = fr_dec;
               if (fr_dec == '0) begin
                  case (desc_ff[7:5])
                     TYPE_BIG_ARRAY:   phase_in = PH_LEN_HI;
                     TYPE_SMALL_ARRAY: phase_in = PH_LEN_LO;
                     default: begin
                        fr_in    = fixed_len(desc_ff[7:5]);
                        phase_in = PH_DATA;
                     end
                  endcase
               end
            end
            PH_LEN_HI: begin
               fr_in    = {1'b0, pb, 8'h00};
               ro_in    = ro_inc;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               fr_in        = (fr_ff | FR_W'(pb)) + 1'b1;
               ro_in        = ro_inc;
               phase_in     = PH_DATA;
               rec.valid    = 1'b1;
               rec.offset   = rd_ff[13:0];
               rec.kind     = desc_ff[7:5];
               rec.name_len = 6'(desc_ff[4:0]) + 1'b1;
               rec.data_len = (fr_ff | FR_W'(pb)) + 1'b1;
            end
            PH_DATA: begin
               ro_in = ro_inc;
               fr_in = fr_dec;
               if (fr_dec == '0) begin
                  idx_in = idx_ff + 1'b1;
                  if (CNT_W'(idx_ff) + 1'b1 >= cnt_ff) begin
                     if (ENTRY_W'(ro_inc) != last_entry_ff) begin
                        err_in = 1'b1;
                     end
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_DESC;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (ctl.item_go) begin
         tail_in = {tail_ff[23:0], ctl.item.data_byte};
         if (pos_ff < POS_W'(MAX_IMAGE_BYTES)) begin
            pos_in = pos_ff + 1'b1;
         end else begin
            err_in = 1'b1;
         end
      end

      if (ctl.clear_go) begin
         pos_in   = '0;
         phase_in = PH_MAGIC;
         cnt_in   = '0;
         idx_in   = '0;
         ro_in    = '0;
         fr_in    = '0;
         desc_in  = 8'h00;
         tail_in  = '0;
         err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_MAGIC;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         ro_ff    <= '0;
         fr_ff    <= '0;
         desc_ff  <= 8'h00;
         tail_ff  <= '0;
         err_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         ro_ff    <= ro_in;
         fr_ff    <= fr_in;
         desc_ff  <= desc_in;
         tail_ff  <= tail_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      last_entry_ff <= last_entry_in;
   end

   // The read port always follows the next item index, so rd_ff is loaded with the
   // entry for the current item at the same edge that moves the index.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[idx_in];
   end

   assign summary.error_seen     = err_ff;
   assign summary.phase_done     = (phase_ff == PH_DONE);
   assign summary.byte_position  = pos_ff;
   assign summary.running_offset = ro_ff;
   assign summary.declared_count = cnt_ff;
   assign summary.tail_bytes     = tail_ff;

endmodule

[hdl/cfgv_status.sv]
// Final verdict of an image: size and magic checks, id table bound and free space.
// Purely combinational from the parser summary; depends on cfgv_pkg.

module cfgv_status (
   input  cfgv_pkg::summary_type        summary,
   input  logic [cfgv_pkg::BUF_W-1:0]   buffer_size,
   input  logic [cfgv_pkg::IDS_W-1:0]   id_table_entries,
   output cfgv_pkg::verdict_type        verdict
);
   import cfgv_pkg::*;

   logic [IDS_W-1:0] ids_eff;
   logic [17:0]      lut_end;
   logic [17:0]      room;
   logic             fits;

   always_comb begin
      ids_eff = (id_table_entries == '0) ? IDS_W'(1) : id_table_entries;
      // The id table starts below the end magic; both values are two's complement.
      lut_end = 18'(buffer_size) - 18'd2 - {6'b0, ids_eff, 1'b0};
      room    = lut_end - 18'(summary.running_offset);
      fits    = !room[17];

      verdict.ok = !summary.error_seen && summary.phase_done && fits
                   && summary.byte_position >= POS_W'(MIN_IMAGE_BYTES)
                   && summary.byte_position <= POS_W'(buffer_size)
                   && summary.tail_bytes == END_MAGIC;

      if (!verdict.ok) begin
         verdict.free_bytes = '0;
      end else if (room[16:FREE_W] != '0) begin
         verdict.free_bytes = '1;
      end else begin
         verdict.free_bytes = room[FREE_W-1:0];
      end
   end

endmodule

[hdl/config_image_validator.sv]
// Top level of the settings image validator: handshakes, configuration
// registers and the end-of-image sequence; depends on cfgv_pkg, cfgv_parser
// and cfgv_status.
//
// Image bytes arrive as requests on req_*, one byte per request, with
// last_byte set on the final byte. Results leave on rsp_*: an item record as
// soon as the record's payload length is known, and one status per image.
// Bytes are examined four positions behind the stream, so a record appears
// while the bytes after it are still arriving.
// A request is registered in the input register on acceptance and parsed into
// the result register once that register is free. One request per cycle is
// taken in a steady stream while the result register is free and no
// end-of-image sequence runs. After a last byte the parser steps through the
// four end magic positions, then a verdict step loads the status into the
// result register; meanwhile one further request may wait in the input register.
// If the receiver holds rsp_ready low, the result register holds its content
// and parsing stops, so req_ready falls once the input register is full. Reset
// clears the parser and restores buffer_size to 16384 and id_table_entries to 35.
// The user must make csr_* writes only while the block is idle; nothing enforces it.

module config_image_validator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cfgv_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cfgv_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [cfgv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cfgv_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cfgv_pkg::*;

   logic                in_valid_ff, in_valid_in;
   req_type             in_item_ff, in_item_in;
   logic                drain_active_ff, drain_active_in;
   logic [DRAIN_W-1:0]  drain_cnt_ff, drain_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [BUF_W-1:0]    buffer_size_ff, buffer_size_in;
   logic [IDS_W-1:0]    id_table_ff, id_table_in;

   logic                slot_free;
   logic                advance;
   logic                status_go;
   logic                rec_go;
   parse_ctl_type       ctl;
   rec_type             rec;
   summary_type         summary;
   verdict_type         verdict;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && !drain_active_ff && slot_free;
   assign req_ready = !in_valid_ff || advance;
   assign status_go = drain_active_ff && drain_cnt_ff == DRAIN_W'(TAIL_BYTES) && slot_free;
   // Records completed by the last byte of an image are checked but not reported.
   assign rec_go    = advance && !in_item_ff.last_byte && rec.valid;

   always_comb begin
      ctl.item_go  = advance;
      ctl.item     = in_item_ff;
      ctl.tail_go  = drain_active_ff && drain_cnt_ff != DRAIN_W'(TAIL_BYTES);
      ctl.tail_sel = drain_cnt_ff[1:0];
      ctl.clear_go = status_go;
   end

   cfgv_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .buffer_size (buffer_size_ff),
      .rec         (rec),
      .summary     (summary)
   );

   cfgv_status u_status (
      .summary          (summary),
      .buffer_size      (buffer_size_ff),
      .id_table_entries (id_table_ff),
      .verdict          (verdict)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      drain_active_in = drain_active_ff;
      drain_cnt_in    = drain_cnt_ff;
      if (advance && in_item_ff.last_byte) begin
         drain_active_in = 1'b1;
         drain_cnt_in    = '0;
      end else if (ctl.tail_go) begin
         drain_cnt_in = drain_cnt_ff + 1'b1;
      end else if (status_go) begin
         drain_active_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rec_go) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.result_kind = RESULT_ITEM;
         rsp_in.status      = STATUS_VALID;
         rsp_in.item_offset = rec.offset;
         rsp_in.item_type   = rec.kind;
         rsp_in.name_length = rec.name_len;
         rsp_in.data_length = rec.data_len;
      end else if (status_go) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.result_kind = RESULT_STATUS;
         rsp_in.status      = verdict.ok ? STATUS_VALID : STATUS_REJECTED;
         rsp_in.item_count  = verdict.ok ? summary.declared_count : '0;
         rsp_in.free_bytes  = verdict.free_bytes;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      buffer_size_in = buffer_size_ff;
      id_table_in    = id_table_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_BUFFER_SIZE: buffer_size_in = csr_wdata;
            REG_ID_TABLE:    id_table_in    = csr_wdata[IDS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         drain_active_ff <= 1'b0;
         drain_cnt_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         buffer_size_ff  <= BUFFER_SIZE_RESET;
         id_table_ff     <= ID_TABLE_RESET;
      end else begin
         in_valid_ff     <= in_valid_in;
         drain_active_ff <= drain_active_in;
         drain_cnt_ff    <= drain_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
         buffer_size_ff  <= buffer_size_in;
         id_table_ff     <= id_table_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A last byte always starts the end-of-image sequence from its first step.
   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.last_byte |=> drain_active_ff && drain_cnt_ff == '0)
      else $error("last byte did not start the end sequence");

   // The verdict step always leaves a status in the result register.
   a_status_loaded: assert property (@(posedge clock) disable iff (reset)
      status_go |=> rsp_valid_ff && rsp_ff.result_kind == RESULT_STATUS)
      else $error("status not presented after verdict step");

   // A rejected image reports neither a count nor free space.
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_REJECTED |->
         rsp_ff.item_count == '0 && rsp_ff.free_bytes == '0)
      else $error("rejected status carries count or free space");

   // Item records never carry a rejection and always a non-zero type.
   a_record_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_kind == RESULT_ITEM |->
         rsp_ff.status == STATUS_VALID && rsp_ff.item_type != TYPE_NONE)
      else $error("malformed item record");

endmodule

[dv/config_image_validator_test.sv]
// Self-checking testbench for config_image_validator: streams settings images as
// requests, predicts every item record and image status, and checks them.
// Depends on cfgv_pkg and the config_image_validator RTL.

module config_image_validator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cfgv_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef logic [7:0] byte_q_type[$];

   localparam logic [3:0] AT_MAGIC    = 4'd0;
   localparam logic [3:0] AT_COUNT_HI = 4'd1;
   localparam logic [3:0] AT_COUNT_LO = 4'd2;
   localparam logic [3:0] AT_TABLE    = 4'd3;
   localparam logic [3:0] AT_DESC     = 4'd4;
   localparam logic [3:0] AT_NAME     = 4'd5;
   localparam logic [3:0] AT_LEN_HI   = 4'd6;
   localparam logic [3:0] AT_LEN_LO   = 4'd7;
   localparam logic [3:0] AT_DATA     = 4'd8;
   localparam logic [3:0] AT_DONE     = 4'd9;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   config_image_validator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state: a mirror of the validator's parser and registers.
   logic [BUF_W-1:0] cfg_buffer_size;
   logic [IDS_W-1:0] cfg_id_entries;
   logic [14:0]      img_pos;
   logic [3:0]       walk_phase;
   logic [15:0]      item_total;
   logic [15:0]      item_idx;
   logic [15:0]      offset_table [MAX_ITEMS];
   logic [16:0]      walk_pos;
   logic [16:0]      field_left;
   logic [7:0]       desc_byte;
   logic [31:0]      byte_window;
   bit               broken;

   req_type image_bytes_q[$];
   rsp_type due_reports[$];
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int rsp_hold_cycles = 0;
   int bytes_queued = 0;
   int bytes_taken = 0;
   int images_sent = 0;
   int records_seen = 0;
   int images_good = 0;
   int images_bad = 0;
   int fail_count = 0;
   int cycle_count = 0;

   function automatic logic [16:0] payload_bytes(input logic [2:0] kind);
      case (kind)
         TYPE_BYTE, TYPE_BOOL: return 17'd1;
         TYPE_SHORT:           return 17'd2;
         TYPE_LONG:            return 17'd4;
         TYPE_LONG_LONG:       return 17'd8;
         default:              return 17'd0;
      endcase
   endfunction

   function automatic logic [16:0] entry_at(input logic [15:0] idx);
      return (idx < MAX_ITEMS) ? {1'b0, offset_table[idx]} : 17'h10000;
   endfunction

   function automatic void finish_items();
      if (walk_pos != entry_at(item_total))
         broken = 1'b1;
      walk_phase = AT_DONE;
   endfunction

   function automatic void reset_walk();
      img_pos = '0;
      walk_phase = AT_MAGIC;
      item_total = '0;
      item_idx = '0;
      walk_pos = '0;
      field_left = '0;
      desc_byte = '0;
      byte_window = '0;
      broken = 1'b0;
   endfunction

   // Walks one image byte through the layout; returns 1 with a record ready.
   function automatic bit parse_image_byte(input logic [7:0] b, output rsp_type rec);
      logic [2:0] kind;
      rec = '0;
      kind = b[7:5];
      if (broken)
         return 1'b0;
      case (walk_phase)
         AT_MAGIC: begin
            if (walk_pos > 3 || b != 8'(START_MAGIC >> (24 - 8 * walk_pos[1:0]))) begin
               broken = 1'b1;
               return 1'b0;
            end
            walk_pos++;
            if (walk_pos == 4)
               walk_phase = AT_COUNT_HI;
         end
         AT_COUNT_HI: begin
            item_total = {b, 8'h00};
            walk_pos++;
            walk_phase = AT_COUNT_LO;
         end
         AT_COUNT_LO: begin
            item_total[7:0] = b;
            walk_pos++;
            if (item_total + 1 > MAX_ITEMS) begin
               broken = 1'b1;
               return 1'b0;
            end
            field_left = 17'(2 * (item_total + 1));
            item_idx = '0;
            walk_phase = AT_TABLE;
         end
         AT_TABLE: begin
            // Even counts left mean the high byte of an offset entry.
            if (!field_left[0]) begin
               desc_byte = b;
            end else begin
               offset_table[item_idx] = {desc_byte, b};
               item_idx++;
            end
            walk_pos++;
            field_left--;
            if (field_left == 0) begin
               item_idx = '0;
               desc_byte = '0;
               if (item_total == 0)
                  finish_items();
               else
                  walk_phase = AT_DESC;
            end
         end
         AT_DESC: begin
            if (walk_pos != entry_at(item_idx) || kind == TYPE_NONE) begin
               broken = 1'b1;
               return 1'b0;
            end
            desc_byte = b;
            field_left = 17'(b[4:0]) + 17'd1;
            walk_phase = AT_NAME;
            if (kind >= TYPE_BYTE) begin
               rec.result_kind = RESULT_ITEM;
               rec.status = STATUS_VALID;
               rec.item_offset = walk_pos[13:0];
               rec.item_type = kind;
               rec.name_length = 6'(b[4:0]) + 6'd1;
               rec.data_length = payload_bytes(kind);
               walk_pos++;
               return 1'b1;
            end
            walk_pos++;
         end
         AT_NAME: begin
            walk_pos++;
            field_left--;
            if (field_left == 0) begin
               if (desc_byte[7:5] == TYPE_BIG_ARRAY) begin
                  walk_phase = AT_LEN_HI;
               end else if (desc_byte[7:5] == TYPE_SMALL_ARRAY) begin
                  walk_phase = AT_LEN_LO;
               end else begin
                  field_left = payload_bytes(desc_byte[7:5]);
                  walk_phase = AT_DATA;
               end
            end
         end
         AT_LEN_HI: begin
            field_left = {b, 8'h00};
            walk_pos++;
            walk_phase = AT_LEN_LO;
         end
         AT_LEN_LO: begin
            field_left = (field_left | 17'(b)) + 17'd1;
            walk_pos++;
            walk_phase = AT_DATA;
            rec.result_kind = RESULT_ITEM;
            rec.status = STATUS_VALID;
            rec.item_offset = 14'(entry_at(item_idx));
            rec.item_type = desc_byte[7:5];
            rec.name_length = 6'(desc_byte[4:0]) + 6'd1;
            rec.data_length = field_left;
            return 1'b1;
         end
         AT_DATA: begin
            walk_pos++;
            field_left--;
            if (field_left == 0) begin
               item_idx++;
               if (item_idx >= item_total)
                  finish_items();
               else
                  walk_phase = AT_DESC;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Takes one accepted request and queues whatever result it causes.
   function automatic void validate_byte(input req_type item);
      rsp_type rec;
      rsp_type verdict;
      bit got;
      bit ok;
      logic [14:0] size;
      logic [7:0] v;
      int slots;
      int lut_end;
      int spare;
      got = 1'b0;
      rec = '0;
      spare = 0;
      // Bytes are parsed four positions late; the newest four wait in the window.
      if (img_pos >= 4)
         got = parse_image_byte(byte_window[31:24], rec);
      byte_window = {byte_window[23:0], item.data_byte};
      if (img_pos < MAX_IMAGE_BYTES)
         img_pos++;
      else
         broken = 1'b1;
      if (!item.last_byte) begin
         if (got) begin
            due_reports.push_back(rec);
            records_seen++;
         end
         return;
      end
      size = img_pos;
      ok = !broken && size >= MIN_IMAGE_BYTES && size <= cfg_buffer_size &&
           byte_window == END_MAGIC;
      if (ok) begin
         // The end magic positions read as zeros unless the image fills the store.
         for (int k = 3; k >= 0; k--) begin
            v = (size == cfg_buffer_size) ? byte_window[8*k +: 8] : 8'h00;
            void'(parse_image_byte(v, rec));
         end
         ok = !broken && walk_phase == AT_DONE;
      end
      if (ok) begin
         slots = (cfg_id_entries == 0) ? 1 : int'(cfg_id_entries);
         lut_end = int'(cfg_buffer_size) - 4 - 2 * (slots - 1);
         if (int'(walk_pos) > lut_end)
            ok = 1'b0;
         else
            spare = (lut_end - int'(walk_pos) > 16383) ? 16383 : lut_end - int'(walk_pos);
      end
      verdict = '0;
      verdict.result_kind = RESULT_STATUS;
      verdict.status = ok ? STATUS_VALID : STATUS_REJECTED;
      if (ok) begin
         verdict.item_count = item_total;
         verdict.free_bytes = spare[13:0];
         images_good++;
      end else begin
         images_bad++;
      end
      due_reports.push_back(verdict);
      reset_walk();
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Request driver: valid is held with its byte until the block accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         cfg_buffer_size = BUFFER_SIZE_RESET;
         cfg_id_entries = ID_TABLE_RESET;
         reset_walk();
      end else begin
         if (req_valid && req_ready) begin
            validate_byte(req_payload);
            bytes_taken++;
         end
         if (!req_valid || req_ready) begin
            if (image_bytes_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= image_bytes_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor, which also decides when the receiver stalls.
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_reports.size() == 0) begin
               $error("result with nothing expected: %p", rsp_payload);
               fail_count++;
            end else begin
               want = due_reports.pop_front();
               check_field("result_kind", want.result_kind, rsp_payload.result_kind);
               check_field("status", want.status, rsp_payload.status);
               check_field("item_offset", want.item_offset, rsp_payload.item_offset);
               check_field("item_type", want.item_type, rsp_payload.item_type);
               check_field("name_length", want.name_length, rsp_payload.name_length);
               check_field("data_length", want.data_length, rsp_payload.data_length);
               check_field("item_count", want.item_count, rsp_payload.item_count);
               check_field("free_bytes", want.free_bytes, rsp_payload.free_bytes);
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic append_word(ref byte_q_type img, input logic [31:0] word);
      for (int k = 3; k >= 0; k--)
         img.push_back(word[8*k +: 8]);
   endtask

   task automatic send_image(input byte_q_type img);
      foreach (img[i])
         image_bytes_q.push_back('{data_byte: img[i], last_byte: (i == img.size() - 1)});
      bytes_queued += img.size();
      images_sent++;
   endtask

   task automatic wait_idle();
      while (bytes_taken != bytes_queued || due_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      wait_idle();
      // The block may still be finishing bytes that produce no result.
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_BUFFER_SIZE)
         cfg_buffer_size = value[BUF_W-1:0];
      else
         cfg_id_entries = value[IDS_W-1:0];
   endtask

   // A well-formed image of n_items records; padded to total_size when that is
   // reachable; else no padding, or a little random free space if total_size is 0.
   task automatic build_image(input int n_items, input int total_size, ref byte_q_type img);
      byte_q_type body;
      logic [15:0] starts[$];
      logic [2:0] kind;
      logic [15:0] len_code;
      int name_len;
      int data_len;
      int pos;
      int pad;
      img = {};
      body = {};
      pos = 6 + 2 * (n_items + 1);
      for (int i = 0; i < n_items; i++) begin
         starts.push_back(16'(pos));
         kind = 3'($urandom_range(TYPE_BIG_ARRAY, TYPE_BOOL));
         name_len = ($urandom_range(9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 4);
         body.push_back({kind, 5'(name_len - 1)});
         repeat (name_len) body.push_back(8'($urandom));
         pos += 1 + name_len;
         if (kind == TYPE_BIG_ARRAY || kind == TYPE_SMALL_ARRAY) begin
            if ($urandom_range(15) == 0 && kind == TYPE_BIG_ARRAY)
               len_code = 16'($urandom_range(256, 600));
            else if ($urandom_range(7) == 0)
               len_code = 16'($urandom_range(255));
            else
               len_code = 16'($urandom_range(5));
            if (kind == TYPE_BIG_ARRAY) begin
               body.push_back(len_code[15:8]);
               pos++;
            end
            body.push_back(len_code[7:0]);
            pos++;
            data_len = int'(len_code) + 1;
         end else begin
            data_len = int'(payload_bytes(kind));
         end
         repeat (data_len) body.push_back(8'($urandom));
         pos += data_len;
      end
      starts.push_back(16'(pos));
      if (total_size > pos + 4)
         pad = total_size - pos - 4;
      else
         pad = (total_size == 0) ? $urandom_range(3) : 0;
      append_word(img, START_MAGIC);
      img.push_back(8'(n_items >> 8));
      img.push_back(8'(n_items));
      foreach (starts[i]) begin
         img.push_back(starts[i][15:8]);
         img.push_back(starts[i][7:0]);
      end
      img = {img, body};
      repeat (pad) img.push_back(8'($urandom));
      append_word(img, END_MAGIC);
   endtask

   // Mostly well-formed images with random content, the rest broken or noise.
   task automatic random_images(input int target_bytes);
      byte_q_type img;
      int sent;
      int mode;
      int cut;
      int fit;
      int n;
      sent = 0;
      while (sent < target_bytes) begin
         mode = $urandom_range(99);
         n = $urandom_range(5);
         fit = (mode < 15 && cfg_buffer_size <= 400) ? int'(cfg_buffer_size) : 0;
         img = {};
         if (mode >= 92) begin
            cut = $urandom_range(1, 20);
            if (cut % 2 == 1)
               append_word(img, START_MAGIC);
            repeat (cut) img.push_back(8'($urandom));
         end else begin
            build_image(n, fit, img);
            if (mode >= 60 && mode < 68) begin
               // End magic laid over the last bytes of the records.
               cut = $urandom_range(1, 4);
               repeat (4 + cut) void'(img.pop_back());
               append_word(img, END_MAGIC);
            end else if (mode >= 68 && mode < 76) begin
               img[$urandom_range(img.size() - 1)] ^= 8'($urandom_range(1, 255));
            end else if (mode >= 76 && mode < 82 && n > 0) begin
               img[6 + 2 * (n + 1)] &= 8'h1F;
            end else if (mode >= 82 && mode < 88) begin
               cut = $urandom_range(1, img.size());
               while (img.size() > cut)
                  void'(img.pop_back());
            end else if (mode >= 88 && mode < 92) begin
               img[4] = 8'($urandom_range(4, 255));
            end
         end
         send_image(img);
         sent += img.size();
      end
   endtask

   initial begin
      byte_q_type img;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 21;
      receiver_idle_pct = 75;
      // Smallest valid image, a one-byte image, and a count with too many items.
      build_image(0, 12, img);
      send_image(img);
      img = {8'h53};
      send_image(img);
      img = {};
      append_word(img, START_MAGIC);
      img = {img, 8'h04, 8'h00, 8'h00, 8'h08};
      append_word(img, END_MAGIC);
      send_image(img);

      write_reg(REG_BUFFER_SIZE, 16384);
      write_reg(REG_ID_TABLE, 1024);
      random_images(200);
      // Long receiver stall while the sender keeps offering requests.
      rsp_hold_cycles = 400;

      sender_idle_pct = 75;
      receiver_idle_pct = 21;
      write_reg(REG_BUFFER_SIZE, 12);
      write_reg(REG_ID_TABLE, 1);
      build_image(0, 12, img);
      send_image(img);
      random_images(30);
      write_reg(REG_BUFFER_SIZE, $urandom_range(40, 160));
      write_reg(REG_ID_TABLE, 0);
      random_images(90);
      wait_idle();
      random_images(90);

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_reg(REG_BUFFER_SIZE, $urandom_range(200, 2000));
      write_reg(REG_ID_TABLE, $urandom_range(1, 1024));
      random_images(100);
      write_reg(REG_BUFFER_SIZE, 16384);
      write_reg(REG_ID_TABLE, 1);
      random_images(120);

      // Cut-short image whose one big array declares the largest length.
      img = {};
      append_word(img, START_MAGIC);
      img = {img, 8'h00, 8'h01, 8'h00, 8'h0A, 8'h00, 8'h0E};
      img.push_back({TYPE_BIG_ARRAY, 5'd0});
      img.push_back(8'($urandom));
      img.push_back(8'hFF);
      img.push_back(8'hFF);
      repeat (8) img.push_back(8'($urandom));
      send_image(img);

      // Largest accepted count, cut short inside its offset table.
      img = {};
      append_word(img, START_MAGIC);
      img = {img, 8'h03, 8'hFF};
      repeat (12) img.push_back(8'($urandom));
      send_image(img);

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Streamed %0d images (%0d bytes) over six register settings.",
               images_sent, bytes_queued);
      $display("Predicted %0d item records; %0d images accepted, %0d rejected.",
               records_seen, images_good, images_bad);
      if (fail_count == 0 && due_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
